>>> hdl/fixed_point_q24_8_alu_unit_macros.svh
// Assertion macros for the Q24.8 ALU.
// Included by modules that carry concurrent checks.
`ifndef FIXED_POINT_Q24_8_ALU_UNIT_MACROS_SVH
`define FIXED_POINT_Q24_8_ALU_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define FXA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FXA_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FXA_ASSERT(label, clk, rst_n, prop, msg)
`define FXA_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

>>> hdl/fxa_pkg.sv
// Package for the Q24.8 ALU: opcodes, widths and the pipeline payload types.
// No dependencies.
package fxa_pkg;
    localparam int FRAC_BITS = 8;
    localparam int DATA_W = 32;
    localparam int NUM_W = DATA_W + FRAC_BITS;
    localparam int DIV_STAGES = 8;
    localparam int BITS_PER_STAGE = NUM_W / DIV_STAGES;

    typedef enum logic [3:0] {
        OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
        OP_EQ = 4'd4, OP_NE = 4'd5, OP_LE = 4'd6, OP_GE = 4'd7,
        OP_LT = 4'd8, OP_GT = 4'd9, OP_MIN = 4'd10, OP_MAX = 4'd11,
        OP_INC = 4'd12, OP_DEC = 4'd13, OP_INT = 4'd14, OP_NONE = 4'd15
    } op_t;

    typedef struct packed {
        logic [3:0]        cmd;
        logic [DATA_W-1:0] operand_a;
        logic [DATA_W-1:0] operand_b;
    } alu_req_t;

    typedef struct packed {
        logic [DATA_W-1:0] result;
        logic              div_by_zero;
    } alu_rsp_t;

    // In-flight item state.
    typedef struct packed {
        logic [3:0]        cmd;
        logic [DATA_W-1:0] simple;
        logic [2*DATA_W-1:0] prod;
        logic [NUM_W-1:0]  quo;
        logic [NUM_W-1:0]  rem;
        logic [DATA_W-1:0] den;
        logic              neg_q;
        logic              dz;
    } stage_t;
endpackage

>>> hdl/fxa_stream_if.sv
// Valid/ready channel interface carrying one packed payload.
// No dependencies.
interface fxa_stream_if #(parameter int W = 1);
    logic valid;
    logic ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> hdl/fxa_front.sv
// Stage 0 of the ALU: simple ops, the full multiply product, divider setup.
// Depends on fxa_pkg.
module fxa_front (
    input  logic              clk,
    input  logic              en,
    input  fxa_pkg::alu_req_t req,
    output fxa_pkg::stage_t   st
);
    import fxa_pkg::*;
    logic signed [DATA_W-1:0] a, b;
    logic signed [2*DATA_W-1:0] prod;
    logic [DATA_W-1:0] simple, ua, ub;
    logic [NUM_W-1:0] num;
    stage_t nxt;

    assign a = $signed(req.operand_a);
    assign b = $signed(req.operand_b);
    assign ua = a[DATA_W-1] ? DATA_W'(-a) : a;
    assign ub = b[DATA_W-1] ? DATA_W'(-b) : b;
    assign num = {ua, {FRAC_BITS{1'b0}}};
    assign prod = a * b;

    always_comb
    begin
        case (op_t'(req.cmd))
            OP_ADD: simple = a + b;
            OP_SUB: simple = a - b;
            OP_EQ:  simple = DATA_W'(a == b);
            OP_NE:  simple = DATA_W'(a != b);
            OP_LE:  simple = DATA_W'(a <= b);
            OP_GE:  simple = DATA_W'(a >= b);
            OP_LT:  simple = DATA_W'(a < b);
            OP_GT:  simple = DATA_W'(a > b);
            OP_MIN: simple = (b < a) ? b : a;
            OP_MAX: simple = (b > a) ? b : a;
            OP_INC: simple = a + 1;
            OP_DEC: simple = a - 1;
            OP_INT: simple = DATA_W'(a >>> FRAC_BITS);
            default: simple = '0;
        endcase
        nxt = '0;
        nxt.cmd = req.cmd;
        nxt.simple = simple;
        nxt.prod = prod;
        nxt.quo = num;
        nxt.rem = '0;
        nxt.den = ub;
        nxt.neg_q = a[DATA_W-1] ^ b[DATA_W-1];
        nxt.dz = (op_t'(req.cmd) == OP_DIV) && (b == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            st <= nxt;
    end
endmodule

>>> hdl/fxa_div_step.sv
// One divider stage: BITS_PER_STAGE restoring steps on the in-flight item.
// Depends on fxa_pkg.
module fxa_div_step (
    input  logic            clk,
    input  logic            en,
    input  fxa_pkg::stage_t st_in,
    output fxa_pkg::stage_t st_out
);
    import fxa_pkg::*;
    stage_t nxt;
    logic [NUM_W:0] trial;

    always_comb
    begin
        nxt = st_in;
        trial = '0;
        for (int i = 0; i < BITS_PER_STAGE; i++)
        begin
            trial = {nxt.rem, nxt.quo[NUM_W-1]} - {{(NUM_W-DATA_W+1){1'b0}}, nxt.den};
            if (!trial[NUM_W])
                nxt.rem = trial[NUM_W-1:0];
            else
                nxt.rem = {nxt.rem[NUM_W-2:0], nxt.quo[NUM_W-1]};
            nxt.quo = {nxt.quo[NUM_W-2:0], ~trial[NUM_W]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            st_out <= nxt;
    end
endmodule

>>> hdl/fixed_point_q24_8_alu_unit.sv
// Q24.8 fixed-point ALU: one result beat per input beat, fully pipelined with
// a stage-0 operand register, eight divider stages of five quotient bits each
// and one result-select stage. A result beat is offered once its input beat has passed
// through all of these registers; one beat is taken every cycle while the output is drained,
// and a held output beat stalls the whole pipe. The divider stage count sets the depth.
`include "fixed_point_q24_8_alu_unit_macros.svh"
module fixed_point_q24_8_alu_unit (
    input logic clk,
    input logic rst_n,
    fxa_stream_if.sink   in_ch,
    fxa_stream_if.source out_ch
);
    import fxa_pkg::*;
    localparam int DEPTH = DIV_STAGES + 2;

    logic [DEPTH-1:0] vld_reg, vld_next;
    logic adv;
    stage_t st [DIV_STAGES+1];
    alu_req_t req;
    alu_rsp_t rsp_next, rsp_reg;
    logic [DATA_W-1:0] q_abs, q_sig;
    logic [2*DATA_W-1:0] psh;

    assign adv = !vld_reg[DEPTH-1] || out_ch.ready;
    assign in_ch.ready = adv;
    assign req = alu_req_t'(in_ch.data);

    fxa_front u_front (.clk(clk), .en(adv), .req(req), .st(st[0]));

    // every stage holds while adv is low
    genvar g;
    generate
        for (g = 0; g < DIV_STAGES; g++)
        begin : g_div
            fxa_div_step u_step (.clk(clk), .en(adv), .st_in(st[g]), .st_out(st[g+1]));
        end
    endgenerate

    always_comb
    begin
        q_abs = st[DIV_STAGES].quo[DATA_W-1:0];
        q_sig = st[DIV_STAGES].neg_q ? DATA_W'(-q_abs) : q_abs;
        psh = {{FRAC_BITS{st[DIV_STAGES].prod[2*DATA_W-1]}},
               st[DIV_STAGES].prod[2*DATA_W-1:FRAC_BITS]};
        rsp_next.div_by_zero = st[DIV_STAGES].dz;
        case (op_t'(st[DIV_STAGES].cmd))
            OP_MUL: rsp_next.result = psh[DATA_W-1:0];
            OP_DIV: rsp_next.result = st[DIV_STAGES].dz ? '0 : q_sig;
            default: rsp_next.result = st[DIV_STAGES].simple;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            rsp_reg <= rsp_next;
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (adv)
            vld_next = {vld_reg[DEPTH-2:0], in_ch.valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign out_ch.valid = vld_reg[DEPTH-1];
    assign out_ch.data = rsp_reg;

    `FXA_ASSERT(a_ready_adv, clk, rst_n, (!out_ch.valid |-> in_ch.ready), "ready low with empty output")
    `FXA_ASSERT(a_hold, clk, rst_n, (out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data)), "output beat dropped")
    `FXA_ASSERT(a_shift, clk, rst_n, (in_ch.valid && in_ch.ready |=> vld_reg[0]), "accepted beat lost")
endmodule

>>> tb/fixed_point_q24_8_alu_unit_tb.sv
// Testbench for the Q24.8 fixed-point ALU: directed corners, random beats with random
// idling on both channels, back-to-back beats, checked by an in-bench predictor.
// Depends on fxa_pkg, fxa_stream_if and fixed_point_q24_8_alu_unit.
module fixed_point_q24_8_alu_unit_tb;
    import fxa_pkg::*;

    localparam int REQ_W = $bits(alu_req_t);
    localparam int RSP_W = $bits(alu_rsp_t);
    localparam int LATENCY = 10;
    localparam int STALL_LIMIT = 2000;

    logic clk;
    logic rst_n;

    fxa_stream_if #(.W(REQ_W)) in_ch ();
    fxa_stream_if #(.W(RSP_W)) out_ch ();

    fixed_point_q24_8_alu_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch),
        .out_ch(out_ch)
    );

    alu_rsp_t expected_rsp_q[$];
    int error_count;
    int beats_sent;
    int beats_checked;
    int idle_cycles = 0;
    bit timed_out;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic alu_rsp_t alu_predict(logic [3:0] cmd, logic signed [31:0] a,
                                            logic signed [31:0] b);
        alu_rsp_t r;
        logic signed [63:0] prod;
        logic signed [39:0] num;
        logic [39:0] mag_n;
        logic [39:0] mag_d;
        logic [39:0] quo;
        r.result = '0;
        r.div_by_zero = 1'b0;
        case (op_t'(cmd))
            OP_ADD: r.result = a + b;
            OP_SUB: r.result = a - b;
            OP_MUL:
            begin
                prod = 64'(a) * 64'(b);
                r.result = 32'(prod >>> FRAC_BITS);
            end
            OP_DIV:
            begin
                if (b == 0)
                    r.div_by_zero = 1'b1;
                else
                begin
                    num = 40'(a) <<< FRAC_BITS;
                    mag_n = num[39] ? -num : num;
                    mag_d = b[31] ? -40'(b) : 40'(b);
                    quo = mag_n / mag_d;
                    if (num[39] != b[31])
                        quo = -quo;
                    r.result = quo[31:0];
                end
            end
            OP_EQ: r.result = 32'(a == b);
            OP_NE: r.result = 32'(a != b);
            OP_LE: r.result = 32'(a <= b);
            OP_GE: r.result = 32'(a >= b);
            OP_LT: r.result = 32'(a < b);
            OP_GT: r.result = 32'(a > b);
            OP_MIN: r.result = (b < a) ? b : a;
            OP_MAX: r.result = (b > a) ? b : a;
            OP_INC: r.result = a + 1;
            OP_DEC: r.result = a - 1;
            OP_INT: r.result = a >>> FRAC_BITS;
            default: r.result = '0;
        endcase
        return r;
    endfunction

    // Valid stays up after a beat so the next one can follow directly.
    task automatic send_beat(logic [3:0] cmd, logic [31:0] a, logic [31:0] b, bit do_idle);
        alu_req_t req;
        int gap;
        gap = do_idle ? int'($urandom_range(12, 0)) : 0;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.cmd = cmd;
        req.operand_a = a;
        req.operand_b = b;
        in_ch.valid <= 1'b1;
        in_ch.data <= req;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        expected_rsp_q.push_back(alu_predict(cmd, a, b));
        beats_sent++;
        @(negedge clk);
    endtask

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(5, 0))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(2, 0) - 1;
            3: return 32'($signed($urandom_range(8192, 0)) - 4096);
            4: return {{16{$urandom_range(1, 0) == 1}}, 16'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    // Sink side: random stall, sample at rising edge.
    initial
    begin
        int stall;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = ($urandom_range(3, 0) == 0) ? $urandom_range(12, 0) : 0;
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        alu_rsp_t got;
        alu_rsp_t exp_rsp;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = out_ch.data;
            if (expected_rsp_q.size() == 0)
            begin
                $error("result beat with no expectation: result=%h", got.result);
                error_count++;
            end
            else
            begin
                exp_rsp = expected_rsp_q.pop_front();
                beats_checked++;
                if (got.result !== exp_rsp.result)
                begin
                    $error("result: expected %h, actual %h", exp_rsp.result, got.result);
                    error_count++;
                end
                if (got.div_by_zero !== exp_rsp.div_by_zero)
                begin
                    $error("div_by_zero: expected %b, actual %b",
                           exp_rsp.div_by_zero, got.div_by_zero);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any accepted beat.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("watchdog expired with %0d results pending", expected_rsp_q.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (expected_rsp_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic test_corners();
        logic [31:0] vals[6];
        vals = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 32'h100, 32'hffff_ff00};
        for (int op = 0; op < 16; op++)
            send_beat(4'(op), vals[op % 6], vals[(op + 2) % 6], 1'b0);
        send_beat(OP_DIV, 32'h7fff_ffff, 32'h0, 1'b0);
        send_beat(OP_DIV, 32'h8000_0000, 32'hffff_ffff, 1'b0);
        send_beat(OP_DIV, 32'hffff_fd80, 32'h200, 1'b0);
        send_beat(OP_MUL, 32'h8000_0000, 32'h8000_0000, 1'b0);
        send_beat(OP_MIN, 32'h1234, 32'h1234, 1'b0);
        send_beat(OP_INT, 32'hffff_ff01, 32'h0, 1'b0);
        send_beat(OP_INC, 32'h7fff_ffff, 32'h0, 1'b0);
        send_beat(OP_DEC, 32'h8000_0000, 32'h0, 1'b0);
    endtask

    task automatic test_random(int count);
        logic [31:0] a;
        logic [31:0] b;
        for (int i = 0; i < count; i++)
        begin
            a = rand_operand();
            b = ($urandom_range(9, 0) == 0) ? a : rand_operand();
            send_beat(4'($urandom_range(15, 0)), a, b, $urandom_range(3, 0) != 0);
        end
    endtask

    task automatic test_back_to_back(int count);
        for (int i = 0; i < count; i++)
            send_beat(4'($urandom_range(15, 0)), $urandom, $urandom, 1'b0);
    endtask

    initial
    begin
        error_count = 0;
        beats_sent = 0;
        beats_checked = 0;
        clk = 1'b0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_corners();
        test_random(200);
        wait_drained();
        test_back_to_back(50);
        test_random(180);
        wait_drained();
        repeat (LATENCY * 3) @(negedge clk);
        $display("Sent %0d beats over all opcodes incl. unused; %0d results checked.",
                 beats_sent, beats_checked);
        if (error_count == 0 && expected_rsp_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
